// File: hdl/ekfd_pkg.sv
// ekfd_pkg: shared types, codes and constants of the K-line frame decoder.
// No dependencies; every other file of the decoder uses it by scoped names.

package ekfd_pkg;

    // Protocol bytes
    localparam logic [7:0] IMMO_OPEN_BYTE = 8'h3E;
    localparam logic [7:0] DIAG_SEL_BYTE  = 8'hCD;
    localparam logic [7:0] NORM_SEL_BYTE  = 8'hFE;

    localparam int unsigned IMMO_LENGTH  = 55;   // immobiliser phase length, 1..63
    localparam int unsigned SPEED_WINDOW = 8;    // frames per speed sum, 1..8
    localparam logic [5:0]  RPM_FACTOR   = 6'd50;

    localparam logic [31:0] TIMEOUT_RESET = 32'd9000000;

    // Input item kind (s_tuser)
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Configuration register indexes
    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_IDLE_DISABLE = 1'b1;

    // Event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_FRAME   = 3'd1;
    localparam logic [2:0] EV_SLIP    = 3'd2;
    localparam logic [2:0] EV_LINKOFF = 3'd3;
    localparam logic [2:0] EV_IMMO    = 3'd4;
    localparam logic [2:0] EV_DIAG    = 3'd5;
    localparam logic [2:0] EV_NORMAL  = 3'd6;

    // Link phase codes
    localparam logic [1:0] PHASE_WAIT   = 2'd0;
    localparam logic [1:0] PHASE_IMMO   = 2'd1;
    localparam logic [1:0] PHASE_DIAG   = 2'd2;
    localparam logic [1:0] PHASE_NORMAL = 2'd3;

    // Link controller to frame checker
    typedef struct packed {
        logic frame_en;   // this byte goes into the frame window
        logic link_off;   // this tick drops the link
    } link_ctl_t;

    // One result word
    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  link_phase;
        logic [13:0] engine_rpm;
        logic [7:0]  vehicle_speed;
        logic        speed_updated;
        logic [7:0]  fault_code;
        logic [7:0]  coolant_raw;
    } result_t;

endpackage

// File: hdl/ekfd_link_ctrl.sv
// ekfd_link_ctrl: immobiliser phase, mode selection and idle timeout tracking.
// Depends on ekfd_pkg.

module ekfd_link_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  logic                 mode,
    input  logic [7:0]           rx_byte,
    input  logic [31:0]          idle_timeout,
    input  logic                 idle_disable,
    output ekfd_pkg::link_ctl_t  ctl,
    output logic [2:0]           ev_link,
    output logic [1:0]           link_phase
);

    logic        immo_done_reg, immo_done_next;
    logic        immo_active_reg, immo_active_next;
    logic [5:0]  immo_count_reg, immo_count_next;
    logic        diag_mode_reg, diag_mode_next;
    logic        normal_mode_reg, normal_mode_next;
    logic [31:0] idle_ticks_reg, idle_ticks_next;
    logic        byte_seen_reg, byte_seen_next;

    logic        open_immo;
    logic        act_now;
    logic [5:0]  cnt_base;
    logic [31:0] idle_inc;

    always_comb begin
        immo_done_next   = immo_done_reg;
        immo_active_next = immo_active_reg;
        immo_count_next  = immo_count_reg;
        diag_mode_next   = diag_mode_reg;
        normal_mode_next = normal_mode_reg;
        idle_ticks_next  = idle_ticks_reg;
        byte_seen_next   = byte_seen_reg;
        ev_link          = ekfd_pkg::EV_NONE;
        ctl.link_off     = 1'b0;
        open_immo        = (rx_byte == ekfd_pkg::IMMO_OPEN_BYTE) && !immo_active_reg;
        act_now          = immo_active_reg || open_immo;
        cnt_base         = open_immo ? 6'd0 : immo_count_reg;
        idle_inc         = (idle_ticks_reg == '1) ? idle_ticks_reg : idle_ticks_reg + 32'd1;

        if (mode == ekfd_pkg::MODE_BYTE) begin
            if (!immo_done_reg) begin
                if (open_immo) begin
                    immo_active_next = 1'b1;
                    immo_count_next  = 6'd0;
                    ev_link          = ekfd_pkg::EV_IMMO;
                end
                if (act_now) begin
                    immo_count_next = cnt_base + 6'd1;
                    if (immo_count_next >= 6'(ekfd_pkg::IMMO_LENGTH)) begin
                        immo_done_next   = 1'b1;
                        immo_active_next = 1'b0;
                    end
                    if (rx_byte == ekfd_pkg::DIAG_SEL_BYTE) begin
                        diag_mode_next   = 1'b1;
                        immo_done_next   = 1'b1;
                        immo_active_next = 1'b0;
                        ev_link          = ekfd_pkg::EV_DIAG;
                    end else if (rx_byte == ekfd_pkg::NORM_SEL_BYTE) begin
                        normal_mode_next = 1'b1;
                        immo_done_next   = 1'b1;
                        immo_active_next = 1'b0;
                        ev_link          = ekfd_pkg::EV_NORMAL;
                    end
                end
            end
            idle_ticks_next = 32'd0;
            byte_seen_next  = 1'b1;
        end else if (byte_seen_reg) begin
            idle_ticks_next = idle_inc;
            if (!idle_disable && (idle_inc > idle_timeout)) begin
                immo_done_next   = 1'b0;
                immo_active_next = 1'b0;
                diag_mode_next   = 1'b0;
                normal_mode_next = 1'b0;
                idle_ticks_next  = 32'd0;
                byte_seen_next   = 1'b0;
                ctl.link_off     = 1'b1;
                ev_link          = ekfd_pkg::EV_LINKOFF;
            end
        end

        ctl.frame_en = (mode == ekfd_pkg::MODE_BYTE) && normal_mode_next;

        if (normal_mode_next) begin
            link_phase = ekfd_pkg::PHASE_NORMAL;
        end else if (diag_mode_next) begin
            link_phase = ekfd_pkg::PHASE_DIAG;
        end else if (immo_active_next) begin
            link_phase = ekfd_pkg::PHASE_IMMO;
        end else begin
            link_phase = ekfd_pkg::PHASE_WAIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            immo_done_reg   <= 1'b0;
            immo_active_reg <= 1'b0;
            immo_count_reg  <= 6'd0;
            diag_mode_reg   <= 1'b0;
            normal_mode_reg <= 1'b0;
            idle_ticks_reg  <= 32'd0;
            byte_seen_reg   <= 1'b0;
        end else if (item_valid) begin
            immo_done_reg   <= immo_done_next;
            immo_active_reg <= immo_active_next;
            immo_count_reg  <= immo_count_next;
            diag_mode_reg   <= diag_mode_next;
            normal_mode_reg <= normal_mode_next;
            idle_ticks_reg  <= idle_ticks_next;
            byte_seen_reg   <= byte_seen_next;
        end
    end

endmodule

// File: hdl/ekfd_frame_check.sv
// ekfd_frame_check: 4-byte frame window, checksum test, sliding on mismatch,
// and the rpm / speed / fault / coolant value registers. Depends on ekfd_pkg.

module ekfd_frame_check (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  ekfd_pkg::link_ctl_t  ctl,
    input  logic [7:0]           rx_byte,
    output logic [2:0]           ev_frame,
    output logic [13:0]          engine_rpm,
    output logic [7:0]           vehicle_speed,
    output logic                 speed_updated,
    output logic [7:0]           fault_code,
    output logic [7:0]           coolant_raw
);

    logic [7:0]  window_reg [4];
    logic [7:0]  window_next [4];
    logic [2:0]  fill_reg, fill_next;
    logic [10:0] speed_sum_reg, speed_sum_next;
    logic [2:0]  speed_frames_reg, speed_frames_next;
    logic [13:0] rpm_reg, rpm_next;
    logic [7:0]  speed_reg, speed_next;
    logic [7:0]  fault_reg, fault_next;
    logic [7:0]  coolant_reg, coolant_next;

    logic [7:0]  csum;
    logic [3:0]  frames_inc;
    logic [13:0] rpm_prod;

    assign csum = window_reg[0] + window_reg[1] + window_reg[2] + window_reg[3];
    assign frames_inc = {1'b0, speed_frames_reg} + 4'd1;
    // both operands at full 14 bits so the product is not cut to 8
    assign rpm_prod = {6'd0, window_reg[0]} * {8'd0, ekfd_pkg::RPM_FACTOR};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            window_next[i] = window_reg[i];
        end
        fill_next         = fill_reg;
        speed_sum_next    = speed_sum_reg;
        speed_frames_next = speed_frames_reg;
        rpm_next          = rpm_reg;
        speed_next        = speed_reg;
        fault_next        = fault_reg;
        coolant_next      = coolant_reg;
        ev_frame          = ekfd_pkg::EV_NONE;
        speed_updated     = 1'b0;

        if (ctl.link_off) begin
            fill_next = 3'd0;
        end else if (ctl.frame_en) begin
            if (!fill_reg[2]) begin
                // still filling the four data slots
                for (int i = 0; i < 4; i++) begin
                    if (fill_reg[1:0] == 2'(i)) begin
                        window_next[i] = rx_byte;
                    end
                end
                fill_next = fill_reg + 3'd1;
            end else if (csum == rx_byte) begin
                rpm_next       = rpm_prod;
                fault_next     = window_reg[2];
                coolant_next   = window_reg[3];
                speed_sum_next = speed_sum_reg + 11'(window_reg[1]);
                if (frames_inc >= 4'(ekfd_pkg::SPEED_WINDOW)) begin
                    speed_next        = speed_sum_next[7:0];
                    speed_sum_next    = 11'd0;
                    speed_frames_next = 3'd0;
                    speed_updated     = 1'b1;
                end else begin
                    speed_frames_next = frames_inc[2:0];
                end
                fill_next = 3'd0;
                ev_frame  = ekfd_pkg::EV_FRAME;
            end else begin
                // checksum miss: drop oldest byte, take this one as newest
                window_next[0] = window_reg[1];
                window_next[1] = window_reg[2];
                window_next[2] = window_reg[3];
                window_next[3] = rx_byte;
                ev_frame       = ekfd_pkg::EV_SLIP;
            end
        end
    end

    assign engine_rpm    = rpm_next;
    assign vehicle_speed = speed_next;
    assign fault_code    = fault_next;
    assign coolant_raw   = coolant_next;

    always_ff @(posedge aclk) begin
        if (item_valid) begin
            for (int i = 0; i < 4; i++) begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg         <= 3'd0;
            speed_sum_reg    <= 11'd0;
            speed_frames_reg <= 3'd0;
            rpm_reg          <= 14'd0;
            speed_reg        <= 8'd0;
            fault_reg        <= 8'd0;
            coolant_reg      <= 8'd0;
        end else if (item_valid) begin
            fill_reg         <= fill_next;
            speed_sum_reg    <= speed_sum_next;
            speed_frames_reg <= speed_frames_next;
            rpm_reg          <= rpm_next;
            speed_reg        <= speed_next;
            fault_reg        <= fault_next;
            coolant_reg      <= coolant_next;
        end
    end

endmodule

// File: hdl/ekfd_out_skid.sv
// ekfd_out_skid: result register with one skid entry, decoupling the result
// channel from the input channel. Depends on ekfd_pkg.

module ekfd_out_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ekfd_pkg::result_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output ekfd_pkg::result_t  out_word
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    ekfd_pkg::result_t out_word_reg;
    ekfd_pkg::result_t skid_word_reg;
    logic              out_free;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : in_word;
        end else if (in_valid && in_ready) begin
            skid_word_reg <= in_word;
        end
    end

endmodule

// File: hdl/ecu_kline_frame_decoder.sv
// ecu_kline_frame_decoder: top level of the K-line frame decoder.
// Depends on ekfd_pkg, ekfd_link_ctrl, ekfd_frame_check and ekfd_out_skid.
//
//  channel   dir  handshake            payload
//  -------   ---  ---------            -------
//  s_        in   s_tvalid/s_tready    s_tuser: mode; s_tdata: rx_byte
//  m_        out  m_tvalid/m_tready    m_tuser: event_res; m_tdata: phase, values
//  cfg_      in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// One word in, one result word out. A word is decoded in the cycle it is
// accepted, its result registered; one word per cycle is sustained while
// m_tready keeps up. The result register plus a one-entry skid keep s_tready
// high while a single result waits; s_tready drops only with the skid full.
// aresetn is synchronous, active low: clears phase state, values and the
// config registers to their defaults. Config writes are always accepted.

module ecu_kline_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tuser,    // [0] mode: 0 byte, 1 tick

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [1:0] link_phase, [15:2] engine_rpm,
                                    // [23:16] vehicle_speed, [24] speed_updated,
                                    // [32:25] fault_code, [40:33] coolant_raw,
                                    // [47:41] zero
    output logic [2:0]  m_tuser,    // [2:0] event_res

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic [31:0] idle_timeout_reg;
    logic        idle_disable_reg;

    logic                s_accept;
    logic                in_ready;
    ekfd_pkg::link_ctl_t ctl;
    logic [2:0]          ev_link;
    logic [2:0]          ev_frame;
    ekfd_pkg::result_t   result;
    ekfd_pkg::result_t   m_word;

    assign cfg_ready = 1'b1;
    assign s_tready  = in_ready;
    assign s_accept  = s_tvalid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= ekfd_pkg::TIMEOUT_RESET;
            idle_disable_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                ekfd_pkg::CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                ekfd_pkg::CFG_IDLE_DISABLE: idle_disable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // phase tracking and idle timeout
    ekfd_link_ctrl u_link (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (s_accept),
        .mode         (s_tuser),
        .rx_byte      (s_tdata),
        .idle_timeout (idle_timeout_reg),
        .idle_disable (idle_disable_reg),
        .ctl          (ctl),
        .ev_link      (ev_link),
        .link_phase   (result.link_phase)
    );

    // frame assembly, checksum and value registers
    ekfd_frame_check u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (s_accept),
        .ctl           (ctl),
        .rx_byte       (s_tdata),
        .ev_frame      (ev_frame),
        .engine_rpm    (result.engine_rpm),
        .vehicle_speed (result.vehicle_speed),
        .speed_updated (result.speed_updated),
        .fault_code    (result.fault_code),
        .coolant_raw   (result.coolant_raw)
    );

    // a frame event overrides the phase event of the same byte
    assign result.event_res = (ev_frame != ekfd_pkg::EV_NONE) ? ev_frame : ev_link;

    ekfd_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (in_ready),
        .in_word   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_word)
    );

    assign m_tuser = m_word.event_res;
    assign m_tdata = {7'd0, m_word.coolant_raw, m_word.fault_code, m_word.speed_updated,
                      m_word.vehicle_speed, m_word.engine_rpm, m_word.link_phase};

    // ---- assertions ----

    // input stalls only while a result is pending on the output
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output register empty");

    // a completed speed sum comes only with a good frame
    a_speed_needs_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && result.speed_updated |-> result.event_res == ekfd_pkg::EV_FRAME)
        else $error("speed update without valid frame");

    // frame events happen only in normal mode
    a_frame_in_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (ev_frame != ekfd_pkg::EV_NONE)
        |-> result.link_phase == ekfd_pkg::PHASE_NORMAL)
        else $error("frame event outside normal mode");

    // link-off returns the phase to waiting
    a_linkoff_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && ctl.link_off |-> result.link_phase == ekfd_pkg::PHASE_WAIT)
        else $error("phase not cleared by link-off");

endmodule

// File: bench/ekfd_decode_check.sv
`timescale 1ns / 1ps
// ekfd_decode_check: watches the decoder's input, result and config channels,
// predicts every result word and compares it field by field. Uses ekfd_pkg.

module ekfd_decode_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          words_pending
);

    localparam int PRINT_CAP = 40;

    // Link timing registers as the decoder should hold them
    logic [31:0] idle_limit;
    logic        idle_hold;

    // Link and frame state
    logic        immo_closed;
    logic        immo_open;
    logic [5:0]  immo_len;
    logic        diag_on;
    logic        normal_on;
    logic [7:0]  win [4];
    logic [2:0]  win_fill;
    logic [10:0] speed_acc;
    logic [2:0]  speed_cnt;
    logic [13:0] rpm_val;
    logic [7:0]  speed_val;
    logic [7:0]  fault_val;
    logic [7:0]  coolant_val;
    logic [31:0] idle_cnt;
    logic        seen_byte;

    ekfd_pkg::result_t readings_due[$];
    int                words_seen;

    initial begin
        fail_count    = 0;
        words_pending = 0;
        words_seen    = 0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("[%0t] result word %0d, %s: got %0d, expected %0d",
                     $time, words_seen, field, got, want);
    endtask

    task automatic clear_decoder();
        idle_limit  = ekfd_pkg::TIMEOUT_RESET;
        idle_hold   = 1'b0;
        immo_closed = 1'b0;
        immo_open   = 1'b0;
        immo_len    = '0;
        diag_on     = 1'b0;
        normal_on   = 1'b0;
        for (int i = 0; i < 4; i++)
            win[i] = '0;
        win_fill    = '0;
        speed_acc   = '0;
        speed_cnt   = '0;
        rpm_val     = '0;
        speed_val   = '0;
        fault_val   = '0;
        coolant_val = '0;
        idle_cnt    = '0;
        seen_byte   = 1'b0;
    endtask

    // Frame window: 4 data bytes then an additive checksum, slide on mismatch
    task automatic feed_frame_byte(input logic [7:0] b, inout logic [2:0] ev,
                                   inout logic upd);
        logic [7:0] sum;
        int         nf;
        if (win_fill < 3'd4) begin
            win[win_fill[1:0]] = b;
            win_fill = win_fill + 3'd1;
        end else begin
            sum = win[0] + win[1] + win[2] + win[3];
            if (sum == b) begin
                rpm_val     = {6'd0, win[0]} * {8'd0, ekfd_pkg::RPM_FACTOR};
                fault_val   = win[2];
                coolant_val = win[3];
                speed_acc   = speed_acc + {3'd0, win[1]};
                nf = speed_cnt + 1;
                if (nf >= ekfd_pkg::SPEED_WINDOW) begin
                    speed_val = speed_acc[7:0];
                    speed_acc = '0;
                    speed_cnt = '0;
                    upd = 1'b1;
                end else begin
                    speed_cnt = nf[2:0];
                end
                win_fill = '0;
                ev = ekfd_pkg::EV_FRAME;
            end else begin
                win[0] = win[1];
                win[1] = win[2];
                win[2] = win[3];
                win[3] = b;
                win_fill = 3'd4;
                ev = ekfd_pkg::EV_SLIP;
            end
        end
    endtask

    task automatic decode_word(input logic mode, input logic [7:0] b,
                               output ekfd_pkg::result_t r);
        logic [2:0] ev;
        logic       upd;
        ev  = ekfd_pkg::EV_NONE;
        upd = 1'b0;
        if (mode == ekfd_pkg::MODE_BYTE) begin
            if (!immo_closed) begin
                if (b == ekfd_pkg::IMMO_OPEN_BYTE && !immo_open) begin
                    immo_open = 1'b1;
                    immo_len  = '0;
                    ev = ekfd_pkg::EV_IMMO;
                end
                if (immo_open) begin
                    immo_len = immo_len + 6'd1;
                    if (immo_len >= ekfd_pkg::IMMO_LENGTH) begin
                        immo_closed = 1'b1;
                        immo_open   = 1'b0;
                    end
                    if (b == ekfd_pkg::DIAG_SEL_BYTE) begin
                        diag_on     = 1'b1;
                        immo_closed = 1'b1;
                        immo_open   = 1'b0;
                        ev = ekfd_pkg::EV_DIAG;
                    end else if (b == ekfd_pkg::NORM_SEL_BYTE) begin
                        normal_on   = 1'b1;
                        immo_closed = 1'b1;
                        immo_open   = 1'b0;
                        ev = ekfd_pkg::EV_NORMAL;
                    end
                end
            end
            // the normal-mode select byte also opens the frame window
            if (normal_on)
                feed_frame_byte(b, ev, upd);
            idle_cnt  = '0;
            seen_byte = 1'b1;
        end else if (seen_byte) begin
            if (idle_cnt != '1)
                idle_cnt = idle_cnt + 32'd1;
            if (!idle_hold && idle_cnt > idle_limit) begin
                immo_closed = 1'b0;
                immo_open   = 1'b0;
                diag_on     = 1'b0;
                normal_on   = 1'b0;
                win_fill    = '0;
                idle_cnt    = '0;
                seen_byte   = 1'b0;
                ev = ekfd_pkg::EV_LINKOFF;
            end
        end

        r.event_res     = ev;
        r.link_phase    = normal_on ? ekfd_pkg::PHASE_NORMAL :
                          diag_on   ? ekfd_pkg::PHASE_DIAG   :
                          immo_open ? ekfd_pkg::PHASE_IMMO   : ekfd_pkg::PHASE_WAIT;
        r.engine_rpm    = rpm_val;
        r.vehicle_speed = speed_val;
        r.speed_updated = upd;
        r.fault_code    = fault_val;
        r.coolant_raw   = coolant_val;
    endtask

    always @(posedge aclk) begin : watch
        ekfd_pkg::result_t want;
        if (!aresetn) begin
            clear_decoder();
            readings_due.delete();
        end else begin
            // a result leaves from the result register, never in its word's own cycle
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("word with nothing pending, event", m_tuser,
                                    ekfd_pkg::EV_NONE);
                end else begin
                    want = readings_due.pop_front();
                    if (m_tuser !== want.event_res)
                        report_mismatch("event_res", m_tuser, want.event_res);
                    if (m_tdata[1:0] !== want.link_phase)
                        report_mismatch("link_phase", m_tdata[1:0], want.link_phase);
                    if (m_tdata[15:2] !== want.engine_rpm)
                        report_mismatch("engine_rpm", m_tdata[15:2], want.engine_rpm);
                    if (m_tdata[23:16] !== want.vehicle_speed)
                        report_mismatch("vehicle_speed", m_tdata[23:16], want.vehicle_speed);
                    if (m_tdata[24] !== want.speed_updated)
                        report_mismatch("speed_updated", m_tdata[24], want.speed_updated);
                    if (m_tdata[32:25] !== want.fault_code)
                        report_mismatch("fault_code", m_tdata[32:25], want.fault_code);
                    if (m_tdata[40:33] !== want.coolant_raw)
                        report_mismatch("coolant_raw", m_tdata[40:33], want.coolant_raw);
                    if (m_tdata[47:41] !== 7'd0)
                        report_mismatch("pad bits", m_tdata[47:41], 0);
                    words_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ekfd_pkg::CFG_IDLE_TIMEOUT)
                    idle_limit = cfg_data;
                else if (cfg_index == ekfd_pkg::CFG_IDLE_DISABLE)
                    idle_hold = cfg_data[0];
            end
            if (s_tvalid && s_tready) begin
                decode_word(s_tuser, s_tdata, want);
                readings_due = {readings_due, want};
            end
        end
        words_pending = readings_due.size();
    end

endmodule

// File: bench/ecu_kline_frame_decoder_test.sv
`timescale 1ns / 1ps
// ecu_kline_frame_decoder_test: stimulus and verdict for the K-line frame decoder.
// Depends on ekfd_pkg, ecu_kline_frame_decoder and the ekfd_decode_check checker.

module ecu_kline_frame_decoder_test;

    localparam int WORD_BUDGET = 1750;     // random words, roughly
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest clean run
    localparam int LONG_HOLD   = 300;      // receiver hold-off, cycles
    localparam int SMALL_LIMIT = 40;       // timeouts we can run out with ticks

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = ekfd_pkg::MODE_BYTE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = ekfd_pkg::CFG_IDLE_TIMEOUT;
    logic [31:0] cfg_data  = '0;

    int          fail_count;
    int          words_pending;

    // sender bookkeeping
    int          words_sent  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    bit          tick_noise  = 1'b0;   // sprinkle ticks between line bytes
    bit          hold_request = 1'b0;  // asks the receiver for one long hold-off
    logic [31:0] cur_timeout = ekfd_pkg::TIMEOUT_RESET;
    logic        cur_disable = 1'b0;

    ecu_kline_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ekfd_decode_check decode_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: the stall style changes over the run (always ready, coin
    // flip, mostly stalled, mostly ready). On request it holds m_tready low
    // for one long hold-off so the result register and the skid fill up and
    // s_tready has to drop.
    initial begin : sink
        int hold_left;
        int style;
        int span;
        hold_left = 0;
        style     = 0;
        span      = 0;
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 96);
            end
            span--;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // One input word. Called and returns at a falling edge. Words go out in
    // bursts; a new burst may start after a gap with s_tvalid low. Within a
    // burst s_tvalid stays high from word to word.
    task automatic push_word(input logic mode, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_word(ekfd_pkg::MODE_BYTE, b);
    endtask

    // tick words carry random don't-care data so every s_tdata bit moves
    task automatic send_ticks(input int n);
        repeat (n) push_word(ekfd_pkg::MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    // line byte with an occasional idle tick in front of it
    task automatic line_byte(input logic [7:0] b);
        if (tick_noise && $urandom_range(0, 15) == 0)
            send_ticks(1);
        send_byte(b);
    endtask

    // Stop sending and wait until every predicted result word has come back,
    // then let anything still inside the decoder settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (words_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // only called with the decoder drained
    task automatic set_link_timing(input logic [31:0] t, input logic d);
        write_reg(ekfd_pkg::CFG_IDLE_TIMEOUT, t);
        write_reg(ekfd_pkg::CFG_IDLE_DISABLE, {31'd0, d});
        cur_timeout = t;
        cur_disable = d;
    endtask

    // 4 data bytes and their mod-256 sum; the head byte may already be out
    // (the normal-mode select byte doubles as the first frame byte)
    task automatic send_frame(input logic [7:0] d0, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [7:0] d3,
                              input bit head_sent, input bit corrupt);
        logic [7:0] chk;
        logic [7:0] flip;
        chk  = d0 + d1 + d2 + d3;
        flip = 8'($urandom_range(1, 255));
        if (corrupt)
            chk = chk ^ flip;
        if (!head_sent)
            line_byte(d0);
        line_byte(d1);
        line_byte(d2);
        line_byte(d3);
        line_byte(chk);
    endtask

    // filler for the immobiliser phase that never selects a mode
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == ekfd_pkg::DIAG_SEL_BYTE || b == ekfd_pkg::NORM_SEL_BYTE)
            b = b ^ 8'h01;
        return b;
    endfunction

    // frame data leaning on the extremes now and then
    function automatic logic [7:0] frame_data();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // One link session: new link timing, some noise, an immobiliser phase
    // that mostly selects normal mode followed by a run of frames, then
    // enough idle ticks to drop the link again.
    task automatic run_session(input int session_no);
        int          kind;
        int          sel;
        int          frames;
        int          f;
        logic [31:0] t;
        logic        d;
        drain();
        kind = $urandom_range(0, 5);
        case (kind)
            0:       t = 32'd0;
            1:       t = 32'd1;
            2:       t = $urandom_range(2, 30);
            3:       t = '1;                   // link-off can never fire
            4:       t = $urandom;
            default: t = ekfd_pkg::TIMEOUT_RESET;
        endcase
        d = ($urandom_range(0, 4) == 0);
        set_link_timing(t, d);
        if (session_no == 3)
            hold_request = 1'b1;

        repeat ($urandom_range(0, 3)) line_byte(8'($urandom_range(0, 255)));
        line_byte(ekfd_pkg::IMMO_OPEN_BYTE);
        // sel: 0..6 normal, 7 diagnostic, 8 phase runs out, 9 broken off
        sel = $urandom_range(0, 9);
        repeat ((sel == 8) ? ekfd_pkg::IMMO_LENGTH + 6 : $urandom_range(0, 12))
            line_byte(plain_byte());

        if (sel <= 6) begin
            line_byte(ekfd_pkg::NORM_SEL_BYTE);
            frames = $urandom_range(3, 24);
            for (f = 0; f < frames; f++) begin
                // a stray byte knocks the window out of step
                if (f != 0 && $urandom_range(0, 19) == 0)
                    line_byte(8'($urandom_range(0, 255)));
                send_frame((f == 0) ? ekfd_pkg::NORM_SEL_BYTE : frame_data(), frame_data(),
                           frame_data(), frame_data(), f == 0,
                           $urandom_range(0, 11) == 0);
            end
        end else if (sel == 7) begin
            line_byte(ekfd_pkg::DIAG_SEL_BYTE);
            repeat ($urandom_range(0, 6)) line_byte(8'($urandom_range(0, 255)));
        end

        // Drop the link. With the reset disabled the idle count keeps running,
        // so re-enabling it should fire on the very next tick.
        if (cur_disable || cur_timeout > SMALL_LIMIT) begin
            send_ticks((cur_disable && cur_timeout <= SMALL_LIMIT) ?
                       cur_timeout + $urandom_range(1, 4) : $urandom_range(1, 8));
            drain();
            if (cur_timeout > SMALL_LIMIT)
                set_link_timing($urandom_range(0, 5), cur_disable);
            if (cur_disable)
                set_link_timing(cur_timeout, 1'b0);
        end
        send_ticks(cur_timeout + 2);
    endtask

    initial begin : stimulus
        int session_no;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, default link timing
        send_ticks(1);                         // tick before any byte: no idle count
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ekfd_pkg::IMMO_OPEN_BYTE);   // immobiliser start
        send_byte(ekfd_pkg::NORM_SEL_BYTE);    // normal mode, also frame byte 0
        send_frame(ekfd_pkg::NORM_SEL_BYTE, 8'h01, 8'h02, 8'h03, 1'b1, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);   // top rpm
        // bad checksum, then the slid window 20 30 40 00 sums to 90
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h30);
        send_byte(8'h40);
        send_byte(8'h00);
        send_byte(8'h90);
        drain();
        set_link_timing(32'd0, 1'b0);
        send_ticks(1);                         // zero timeout: first tick drops link
        send_byte(ekfd_pkg::IMMO_OPEN_BYTE);
        send_byte(ekfd_pkg::DIAG_SEL_BYTE);    // diagnostic mode
        send_ticks(1);

        // Random sessions until the word budget is spent
        tick_noise = 1'b1;
        session_no = 0;
        while (words_sent < WORD_BUDGET) begin
            run_session(session_no);
            session_no++;
        end

        drain();
        repeat (8) @(negedge aclk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
